// ----- hdl/lzohc_pkg.sv -----
package lzohc_pkg;

    localparam int DIM_W = 12;
    localparam int OFS_W = 22;

    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_SET   = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;
    localparam logic [1:0] KIND_CLICK = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD     = 2'd1;
    localparam logic [1:0] ST_OUTSIDE = 2'd2;

    localparam logic [1:0] CFG_VP_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_VP_HEIGHT = 2'd1;

    typedef struct packed {
        logic [1:0]              kind;
        logic [2:0]              slot;
        logic signed [DIM_W-1:0] pos_x;
        logic signed [DIM_W-1:0] pos_y;
        logic [DIM_W-1:0]        size_w;
        logic [DIM_W-1:0]        size_h;
        logic                    visible;
    } in_item_t;

    typedef struct packed {
        logic             covered;
        logic [2:0]       hit_layer;
        logic [OFS_W-1:0] source_offset;
        logic             focus_valid;
        logic [2:0]       focus_layer;
        logic [1:0]       status;
    } out_item_t;

    // sequencing commands from controller to datapath
    typedef struct packed {
        logic load;
        logic cmp;
        logic pick;
        logic fin;
    } lzohc_cmd_t;

endpackage

// ----- hdl/lzohc_ctrl.sv -----
module lzohc_ctrl
    import lzohc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    output lzohc_cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_PICK = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:   state_next = S_PICK;
            S_PICK:  state_next = S_FIN;
            S_FIN:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy     = (state_reg != S_IDLE);
    assign cmd.load = (state_reg == S_IDLE) && start;
    assign cmd.cmp  = (state_reg == S_CMP);
    assign cmd.pick = (state_reg == S_PICK);
    assign cmd.fin  = (state_reg == S_FIN);

endmodule

// ----- hdl/lzohc_dp.sv -----
module lzohc_dp
    import lzohc_pkg::*;
#(
    parameter int LAYERS  = 8,
    parameter int MAX_DIM = 2048
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  lzohc_cmd_t  cmd,
    input  in_item_t    item,
    input  logic        cfg_valid,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data,
    output logic        done,
    output out_item_t   result
);

    localparam int IW = (LAYERS > 1) ? $clog2(LAYERS) : 1;
    localparam int CW = $clog2(LAYERS + 1);
    localparam logic [CW-1:0] FULL = CW'(LAYERS);

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        if (32'(v) > MAX_DIM)
        begin
            return DIM_W'(MAX_DIM);
        end
        return v;
    endfunction

    // configuration
    logic [DIM_W-1:0] vp_w_reg;
    logic [DIM_W-1:0] vp_h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_w_reg <= '0;
            vp_h_reg <= '0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_VP_WIDTH)
            begin
                vp_w_reg <= clamp_dim(cfg_data);
            end
            else if (cfg_index == CFG_VP_HEIGHT)
            begin
                vp_h_reg <= clamp_dim(cfg_data);
            end
        end
    end

    // latched item, sizes saturated on the way in
    in_item_t it_reg;
    in_item_t item_sat;

    always_comb
    begin
        item_sat        = item;
        item_sat.size_w = clamp_dim(item.size_w);
        item_sat.size_h = clamp_dim(item.size_h);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            it_reg <= item_sat;
        end
    end

    // layer table
    logic signed [DIM_W-1:0] left_reg  [LAYERS];
    logic signed [DIM_W-1:0] top_reg   [LAYERS];
    logic [DIM_W-1:0]        wid_reg   [LAYERS];
    logic [DIM_W-1:0]        hgt_reg   [LAYERS];
    logic [IW-1:0]           zord_reg  [LAYERS];
    logic [LAYERS-1:0]       shown_reg;
    logic [CW-1:0]           count_reg;
    logic                    focus_reg;
    logic [IW-1:0]           front_reg;

    // per-slot hit lanes
    logic [LAYERS-1:0] cov_slot;
    logic [LAYERS-1:0] cov_z;
    logic [LAYERS-1:0] cov_reg;

    for (genvar g = 0; g < LAYERS; g++)
    begin : g_lane
        logic signed [DIM_W+1:0] right;
        logic signed [DIM_W+1:0] bottom;
        logic signed [DIM_W+1:0] px;
        logic signed [DIM_W+1:0] py;
        assign right  = (DIM_W+2)'(left_reg[g]) + $signed({2'b00, wid_reg[g]});
        assign bottom = (DIM_W+2)'(top_reg[g]) + $signed({2'b00, hgt_reg[g]});
        assign px     = (DIM_W+2)'(it_reg.pos_x);
        assign py     = (DIM_W+2)'(it_reg.pos_y);
        assign cov_slot[g] = shown_reg[g]
                           && (px >= (DIM_W+2)'(left_reg[g])) && (px < right)
                           && (py >= (DIM_W+2)'(top_reg[g])) && (py < bottom);
        assign cov_z[g] = (CW'(g) < count_reg) && cov_slot[zord_reg[g]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cmp)
        begin
            cov_reg <= cov_z;
        end
    end

    // topmost covering z position
    logic          found;
    logic [IW-1:0] pos;

    always_comb
    begin
        found = 1'b0;
        pos   = '0;
        for (int i = 0; i < LAYERS; i++)
        begin
            if (cov_reg[i])
            begin
                found = 1'b1;
                pos   = IW'(i);
            end
        end
    end

    logic                  found_reg;
    logic [IW-1:0]         pos_reg;
    logic [IW-1:0]         hs_reg;
    logic [DIM_W-1:0]      row_reg;
    logic [DIM_W-1:0]      col_reg;
    logic [DIM_W-1:0]      hw_reg;
    logic [IW-1:0]         hs;

    assign hs = zord_reg[pos];

    always_ff @(posedge clk)
    begin
        if (cmd.pick)
        begin
            found_reg <= found;
            pos_reg   <= pos;
            hs_reg    <= hs;
            row_reg   <= DIM_W'(it_reg.pos_y - top_reg[hs]);
            col_reg   <= DIM_W'(it_reg.pos_x - left_reg[hs]);
            hw_reg    <= wid_reg[hs];
        end
    end

    // final stage: table updates and result
    logic              outside;
    logic [CW-1:0]     last;
    logic [IW-1:0]     new_slot;
    logic [2*DIM_W-1:0] prod;
    out_item_t         result_next;
    logic              focus_next;
    logic [IW-1:0]     front_next;

    assign outside  = it_reg.pos_x[DIM_W-1] || it_reg.pos_y[DIM_W-1]
                    || (DIM_W'(it_reg.pos_x) >= vp_w_reg)
                    || (DIM_W'(it_reg.pos_y) >= vp_h_reg);
    assign last     = count_reg - CW'(1);
    assign new_slot = IW'(count_reg);
    assign prod     = row_reg * hw_reg;

    always_comb
    begin
        result_next = '0;
        focus_next  = focus_reg;
        front_next  = front_reg;
        case (it_reg.kind)
            KIND_ADD:
            begin
                if (count_reg >= FULL)
                begin
                    result_next.status = ST_BAD;
                end
                else
                begin
                    focus_next            = 1'b1;
                    front_next            = new_slot;
                    result_next.hit_layer = 3'(new_slot);
                end
            end
            KIND_SET:
            begin
                if (32'(it_reg.slot) >= 32'(count_reg))
                begin
                    result_next.status = ST_BAD;
                end
            end
            KIND_QUERY:
            begin
                if (outside)
                begin
                    result_next.status = ST_OUTSIDE;
                end
                else if (found_reg)
                begin
                    result_next.covered       = 1'b1;
                    result_next.hit_layer     = 3'(hs_reg);
                    result_next.source_offset = OFS_W'(prod + (2*DIM_W)'(col_reg));
                end
            end
            default:
            begin
                if (count_reg == '0)
                begin
                    focus_next = 1'b0;
                end
                else if (found_reg)
                begin
                    focus_next            = 1'b1;
                    front_next            = hs_reg;
                    result_next.hit_layer = 3'(hs_reg);
                end
            end
        endcase
        result_next.focus_valid = focus_next;
        result_next.focus_layer = focus_next ? 3'(front_next) : 3'd0;
    end

    logic set_ok;
    logic add_ok;
    logic [IW-1:0] wslot;

    assign add_ok = (it_reg.kind == KIND_ADD) && (count_reg < FULL);
    assign set_ok = (it_reg.kind == KIND_SET) && (32'(it_reg.slot) < 32'(count_reg));
    assign wslot  = add_ok ? new_slot : IW'(it_reg.slot);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shown_reg <= '0;
            count_reg <= '0;
            focus_reg <= 1'b0;
            front_reg <= '0;
            done      <= 1'b0;
        end
        else
        begin
            done <= cmd.fin;
            if (cmd.fin)
            begin
                focus_reg <= focus_next;
                front_reg <= front_next;
                if (add_ok || set_ok)
                begin
                    shown_reg[wslot] <= it_reg.visible;
                end
                if (add_ok)
                begin
                    count_reg <= count_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fin)
        begin
            result <= result_next;
            if (add_ok || set_ok)
            begin
                left_reg[wslot] <= it_reg.pos_x;
                top_reg[wslot]  <= it_reg.pos_y;
                wid_reg[wslot]  <= it_reg.size_w;
                hgt_reg[wslot]  <= it_reg.size_h;
            end
            if (add_ok)
            begin
                zord_reg[wslot] <= new_slot;
            end
            if ((it_reg.kind == KIND_CLICK) && (count_reg != '0) && found_reg)
            begin
                for (int i = 0; i < LAYERS; i++)
                begin
                    if (CW'(i) == last)
                    begin
                        zord_reg[i] <= hs_reg;
                    end
                    else if ((CW'(i) >= CW'(pos_reg)) && (CW'(i) < last))
                    begin
                        zord_reg[i] <= zord_reg[(i + 1) % LAYERS];
                    end
                end
            end
        end
    end

endmodule

// ----- hdl/layer_z_order_hit_compositor.sv -----
// Layer table with z order and hit testing.
// Item channel: present an item on 'item' with 'start' high; it is taken at a
// clock edge where start is high and busy is low. Kinds: add layer on top,
// set a layer's geometry, query one viewport pixel, click to raise a layer.
// Result: one beat per item on 'result', marked by 'done' for exactly one
// cycle. The receiver cannot stall; it must take the beat in that cycle.
// After the accepting edge the item passes the registered steps lane
// compare, topmost pick, then multiply and table update, after which done
// rises. The controller's four-state sequence takes no new item until the
// last one is through; busy drops in the cycle done is high, so the next
// item may be taken at the edge that ends it.
// Config channel: cfg_valid/cfg_ready with cfg_index (0 viewport width,
// 1 viewport height) and cfg_data; cfg_ready is always high. Write only while
// idle. Sizes saturate at MAX_DIM.
// Reset (rst_n low, async): table empty, no focus, viewport 0 by 0, so
// every query reports outside until the viewport is written.
module layer_z_order_hit_compositor
    import lzohc_pkg::*;
#(
    parameter int LAYERS  = 8,
    parameter int MAX_DIM = 2048
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  in_item_t    item,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data,
    output logic        done,
    output out_item_t   result
);

    lzohc_cmd_t cmd;

    assign cfg_ready = 1'b1;

    // sequencer
    lzohc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    // table, compare lanes, offset multiply
    lzohc_dp #(
        .LAYERS  (LAYERS),
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .item      (item),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .result    (result)
    );

endmodule
